// ===== sv/sha256_pkg.sv =====
// Package for the SHA-256 byte stream hasher: sequencer states, constants and
// the round-constant and initial-hash lookup functions. No dependencies.
`default_nettype none
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } seq_state_t;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428A2F98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hB5C0FBCF;
            6'd3:  k = 32'hE9B5DBA5; 6'd4:  k = 32'h3956C25B; 6'd5:  k = 32'h59F111F1;
            6'd6:  k = 32'h923F82A4; 6'd7:  k = 32'hAB1C5ED5; 6'd8:  k = 32'hD807AA98;
            6'd9:  k = 32'h12835B01; 6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE; 6'd14: k = 32'h9BDC06A7;
            6'd15: k = 32'hC19BF174; 6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC; 6'd20: k = 32'h2DE92C6F;
            6'd21: k = 32'h4A7484AA; 6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D; 6'd26: k = 32'hB00327C8;
            6'd27: k = 32'hBF597FC7; 6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27B70A85;
            6'd33: k = 32'h2E1B2138; 6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB; 6'd38: k = 32'h81C2C92E;
            6'd39: k = 32'h92722C85; 6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3; 6'd44: k = 32'hD192E819;
            6'd45: k = 32'hD6990624; 6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08; 6'd50: k = 32'h2748774C;
            6'd51: k = 32'h34B0BCB5; 6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3; 6'd56: k = 32'h748F82EE;
            6'd57: k = 32'h78A5636F; 6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB; 6'd62: k = 32'hBEF9A3F7;
            default: k = 32'hC67178F2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6A09E667; 3'd1: h = 32'hBB67AE85;
            3'd2: h = 32'h3C6EF372; 3'd3: h = 32'hA54FF53A;
            3'd4: h = 32'h510E527F; 3'd5: h = 32'h9B05688C;
            3'd6: h = 32'h1F83D9AB; default: h = 32'h5BE0CD19;
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

// ===== sv/sha256_round.sv =====
// One SHA-256 round and one message schedule step, purely combinational.
// Depends on sha256_pkg for nothing but the shared house conventions.
`default_nettype none
module sha256_round
    import sha256_pkg::*;
(
    input  wire logic [255:0] vars_in,
    input  wire logic [31:0]  w,
    input  wire logic [31:0]  k,
    input  wire logic [31:0]  w16,
    input  wire logic [31:0]  w15,
    input  wire logic [31:0]  w7,
    input  wire logic [31:0]  w2,
    output logic      [255:0] vars_out,
    output logic      [31:0]  w_new
);
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;

    always_comb
    begin
        {a, b, c, d, e, f, g, h} = vars_in;
        t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
               + ((e & f) ^ (~e & g)) + k + w;
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
               + ((a & b) ^ (a & c) ^ (b & c));
        vars_out = {t1 + t2, a, b, c, d + t1, e, f, g};
        s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        w_new = w16 + s0 + w7 + s1;
    end
endmodule
`default_nettype wire

// ===== sv/sha256_byte_stream_hasher.sv =====
// Each transaction carries at most one byte. A byte that fills a 64-byte block stalls the
// input while the block is compressed (a load, the rounds of the shared round unit, an
// add); other transactions leave the input ready. A last transaction pads and compresses
// one more block when the length fits in the current block, two when it needs a second
// block, or, when its byte itself filled the block, that block and then a padded one; the
// digest is then offered and must be taken before the next input.
`default_nettype none
module sha256_byte_stream_hasher
    import sha256_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tuser,   // has_byte
    input  wire logic         s_tlast,   // last_item
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [255:0] m_tdata    // digest_part0, part1, part2, part3
);
    seq_state_t  state_reg, state_next;
    logic [31:0] hash_reg [8];
    logic [31:0] win_reg [16];
    logic [255:0] vars_reg, vars_rnd;
    logic [6:0]  fill_reg;
    logic [63:0] count_reg;
    logic [5:0]  round_reg;
    logic        final_reg, mark_reg, len_reg;
    logic [31:0] w_sched, w_cur;
    logic [63:0] bits;
    logic        acc;

    assign acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = {hash_reg[6], hash_reg[7], hash_reg[4], hash_reg[5],
                      hash_reg[2], hash_reg[3], hash_reg[0], hash_reg[1]};
    assign bits = {count_reg[60:0], 3'b000};
    assign w_cur = (round_reg[5:4] == 2'b00) ? win_reg[round_reg[3:0]] : w_sched;

    sha256_round u_round (
        .vars_in (vars_reg),
        .w       (w_cur),
        .k       (round_k(round_reg)),
        .w16     (win_reg[round_reg[3:0]]),
        .w15     (win_reg[round_reg[3:0] + 4'd1]),
        .w7      (win_reg[round_reg[3:0] + 4'd9]),
        .w2      (win_reg[round_reg[3:0] + 4'd14]),
        .vars_out(vars_rnd),
        .w_new   (w_sched)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (s_tuser && fill_reg == 7'd63)
                        state_next = ST_LOAD;
                    else if (s_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:   state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: if (round_reg == 6'd63) state_next = ST_ADD;
            ST_ADD:
            begin
                if (!final_reg)
                    state_next = ST_IDLE;
                else if (len_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_PAD;
            end
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            count_reg <= '0;
            round_reg <= '0;
            final_reg <= 1'b0;
            mark_reg  <= 1'b0;
            len_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= init_h(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        final_reg <= s_tlast;
                        mark_reg  <= 1'b0;
                        len_reg   <= 1'b0;
                        if (s_tuser)
                        begin
                            count_reg <= count_reg + 64'd1;
                            fill_reg  <= (fill_reg == 7'd63) ? 7'd0 : fill_reg + 7'd1;
                        end
                    end
                end
                ST_PAD:
                begin
                    mark_reg <= 1'b1;
                    len_reg  <= mark_reg || (fill_reg[5:0] < LEN_START);
                end
                ST_LOAD:
                begin
                    round_reg <= '0;
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + vars_reg[255 - 32*i -: 32];
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        fill_reg  <= '0;
                        count_reg <= '0;
                        final_reg <= 1'b0;
                        mark_reg  <= 1'b0;
                        len_reg   <= 1'b0;
                        for (int i = 0; i < 8; i++)
                            hash_reg[i] <= init_h(3'(i));
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Message bytes go straight into the schedule window, big-endian within each word.
    // The pad pass places the 0x80 byte once, clears the rest and adds the bit length
    // when it fits in the block being built.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && s_tuser)
                    win_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= s_tdata;
            end
            ST_LOAD:
            begin
                vars_reg <= {hash_reg[0], hash_reg[1], hash_reg[2], hash_reg[3],
                             hash_reg[4], hash_reg[5], hash_reg[6], hash_reg[7]};
            end
            ST_ROUND:
            begin
                vars_reg <= vars_rnd;
                if (round_reg[5:4] != 2'b00)
                    win_reg[round_reg[3:0]] <= w_sched;
            end
            ST_PAD:
            begin
                for (int j = 0; j < 64; j++)
                begin
                    if (!mark_reg && 6'(j) == fill_reg[5:0])
                        win_reg[4'(j >> 2)][8*(3 - (j & 3)) +: 8] <= PAD_BYTE;
                    else if (6'(j) >= LEN_START
                             && (mark_reg || fill_reg[5:0] < LEN_START))
                        win_reg[4'(j >> 2)][8*(3 - (j & 3)) +: 8] <= bits[8*(63-j) +: 8];
                    else if (mark_reg || 6'(j) > fill_reg[5:0])
                        win_reg[4'(j >> 2)][8*(3 - (j & 3)) +: 8] <= 8'h00;
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/sha256_checker.sv =====
// Port-level checks for the SHA-256 byte stream hasher, bound to its top level.
// Depends on sha256_byte_stream_hasher only through its ports.
`default_nettype none
module sha256_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [255:0] m_tdata
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("Input ready while digest pending.");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Digest dropped or changed while stalled.");
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> s_tready)
        else $error("Not ready after digest transaction.");
    a_reset_ready: assert property (@(posedge clk)
        $rose(rst_n) |-> s_tready) else $error("Not ready after reset.");
endmodule

bind sha256_byte_stream_hasher sha256_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the SHA-256 byte stream hasher: drives byte
// streams, predicts each digest with its own SHA-256 and scores the outputs.
// Depends on sha256_pkg and sha256_byte_stream_hasher.
`timescale 1ns / 100ps

class digest_scoreboard;
    logic [255:0] pending_digests[$];
    int unsigned  mismatches;
    int unsigned  digests_checked;

    function void note_digest(logic [255:0] d);
        pending_digests.push_back(d);
    endfunction

    function void check_digest(logic [255:0] got);
        logic [255:0] want;
        if (pending_digests.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected digest transaction: %h", got);
            return;
        end
        want = pending_digests.pop_front();
        digests_checked++;
        for (int p = 0; p < 4; p++)
        begin
            if (got[64*p +: 64] !== want[64*p +: 64])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("digest_part%0d mismatch: expected %h, got %h",
                             p, want[64*p +: 64], got[64*p +: 64]);
            end
        end
    endfunction
endclass

module tb;
    import sha256_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;

    digest_scoreboard board = new();

    logic [31:0]  hash_state[8];
    logic [7:0]   block_buf[64];
    int unsigned  block_len;
    logic [63:0]  byte_total;
    int unsigned  items_sent;
    int unsigned  messages_sent;
    bit           rx_stall_enable = 1'b1;

    localparam logic [31:0] SHA_K[64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
        32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
        32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
        32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
        32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
        32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
    localparam logic [31:0] SHA_H0[8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
    localparam logic [7:0] MSG_PAD = 8'h80;
    localparam int         LEN_OFFSET = 56;

    sha256_byte_stream_hasher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] ror32(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void compress_buffer();
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        v = hash_state;
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endfunction

    function automatic void predict_item(logic [7:0] data, logic has_byte, logic last);
        logic [63:0]  bit_len;
        logic [255:0] d;
        if (has_byte)
        begin
            block_buf[block_len] = data;
            block_len++;
            byte_total++;
            if (block_len == 64)
            begin
                compress_buffer();
                block_len = 0;
            end
        end
        if (!last)
            return;
        bit_len = byte_total << 3;
        block_buf[block_len] = MSG_PAD;
        block_len++;
        if (block_len > LEN_OFFSET)
        begin
            for (int i = block_len; i < 64; i++)
                block_buf[i] = 8'h00;
            compress_buffer();
            block_len = 0;
        end
        for (int i = block_len; i < LEN_OFFSET; i++)
            block_buf[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            block_buf[63-i] = bit_len[8*i +: 8];
        compress_buffer();
        for (int i = 0; i < 4; i++)
            d[64*i +: 64] = {hash_state[2*i], hash_state[2*i+1]};
        board.note_digest(d);
        hash_state = SHA_H0;
        block_len = 0;
        byte_total = 0;
        messages_sent++;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 90);
    endfunction

    task automatic send_item(logic [7:0] data, logic has_byte, logic last, bit gaps);
        int gap;
        gap = gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(data, has_byte, last);
        items_sent++;
    endtask

    task automatic send_message(int len, bit empty_tail, bit gaps);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, gaps);
            if (i == len - 1 && !empty_tail)
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1, gaps);
            else
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, gaps);
        end
        if (empty_tail || len == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, gaps);
    endtask

    task automatic drain_digests();
        s_tvalid <= 1'b0;
        while (board.pending_digests.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            board.check_digest(m_tdata);
        if (rx_stall_enable && $urandom_range(0, 99) < 30)
            m_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        hash_state = SHA_H0;
        block_len  = 0;
        byte_total = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        send_item(8'h61, 1'b1, 1'b0, 1'b0);
        send_item(8'h62, 1'b1, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1, 1'b0);
        drain_digests();

        send_message(55, 1'b0, 1'b1);
        send_message(56, 1'b0, 1'b1);
        send_message(63, 1'b1, 1'b1);
        send_message(64, 1'b0, 1'b0);
        send_message(64, 1'b1, 1'b1);
        drain_digests();

        rx_stall_enable = 1'b0;
        send_message(20, 1'b0, 1'b0);
        rx_stall_enable = 1'b1;

        while (items_sent < 1000)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'b1);
            else
                send_message($urandom_range(0, 9) == 0 ? $urandom_range(60, 140)
                                                      : $urandom_range(0, 20),
                             $urandom_range(0, 3) == 0, 1'b1);
            if ($urandom_range(0, 19) == 0)
                drain_digests();
        end

        drain_digests();
        $display("Sent %0d transactions in %0d messages; %0d digests checked.",
                 items_sent, messages_sent, board.digests_checked);
        if (board.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout with %0d digests outstanding.", board.pending_digests.size());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
sv/sha256_pkg.sv
sv/sha256_round.sv
sv/sha256_byte_stream_hasher.sv
sv/sha256_checker.sv
tb/tb.sv
